// ----- sv/clsr_pkg.sv -----
// Constants, state codes and arithmetic helpers for the combined LCG shuffle generator.
// Used by combined_lcg_shuffle_random_top; depends on nothing else.
package clsr_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int WARMUP_EXTRA    = 8;

  localparam logic [30:0] MOD1      = 31'd2147483563;
  localparam logic [30:0] MOD2      = 31'd2147483399;
  localparam logic [15:0] MUL1      = 16'd40014;
  localparam logic [15:0] MUL2      = 16'd40692;
  // 2^31 - MOD1 and 2^31 - MOD2: weight of the bits above bit 30 after reduction
  localparam logic [7:0]  FOLD1     = 8'd85;
  localparam logic [7:0]  FOLD2     = 8'd249;
  localparam logic [30:0] GEN2_INIT = 31'd123456789;
  localparam logic [31:0] FRAC_CAP  = 32'd4294966780;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FOLD  = 8'b0000_0010,
    S_UPD   = 8'b0000_0100,
    S_FIN   = 8'b0000_1000,
    S_WFOLD = 8'b0001_0000,
    S_WUPD  = 8'b0010_0000,
    S_WSLOT = 8'b0100_0000,
    S_MUL   = 8'b1000_0000
  } state_t;

  // Reduce a 47-bit product modulo m = 2^31 - c. One fold leaves less than 2m.
  function automatic logic [30:0] mod_fold(input logic [46:0] p, input logic [7:0] c,
                                           input logic [30:0] m);
    logic [31:0] s;
    logic [32:0] d;
    s = 32'(p[46:31]) * 32'(c) + 32'(p[30:0]);
    d = {1'b0, s} - {2'b00, m};
    return d[32] ? s[30:0] : d[30:0];
  endfunction

  // floor(x * 2^32 / MOD1), capped. 2^32 = 2*MOD1 + 2*FOLD1, so the quotient is
  // 2x + floor(170x / MOD1), and the second term is folded like mod_fold.
  function automatic logic [31:0] frac_q32(input logic [30:0] x);
    logic [38:0] t;
    logic [31:0] u;
    logic [31:0] q;
    logic        cy;
    t  = ({8'd0, x} << 7) + ({8'd0, x} << 5) + ({8'd0, x} << 3) + ({8'd0, x} << 1);
    u  = 32'(t[38:31]) * 32'(FOLD1) + 32'(t[30:0]);
    cy = (u >= {1'b0, MOD1});
    q  = {x, 1'b0} + 32'(t[38:31]) + 32'(cy);
    return (q > FRAC_CAP) ? FRAC_CAP : q;
  endfunction

endpackage

// ----- sv/combined_lcg_shuffle_random_top.sv -----
// Combined two-generator multiplicative random source with a Bays-Durham shuffle table.
// Top level; depends on clsr_pkg.
//
// Each accepted item carries a seed and yields one result: the first generator's new
// value (next_seed), the shuffled sample, and sample/MOD1 as an unsigned Q0.32 fraction.
// A positive seed goes through the two-stage modular multiplier (31x16 product, then fold
// and reduce; the fold is S_FOLD), then S_UPD does the single read-modify-write of the
// shuffle memory and S_FIN loads the output register once it is free; no new item is
// taken before that. A seed of zero or below re-seeds the block and runs TABLE_DEPTH+8
// warm-up steps through the same multiplier, each an S_WFOLD/S_WUPD pair, then sets the
// slot (S_WSLOT), forms the product (S_MUL) and continues as for a positive seed. The
// next item is taken as soon as the previous one is written to the output register,
// even while that result is still stalled. The shuffle memory reads as zero after reset
// through per-entry valid bits; no clearing pass is needed.
module combined_lcg_shuffle_random_top #(
  parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] seed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [30:0] next_seed,
  output logic        [30:0] sample,
  output logic        [31:0] fraction
);
  import clsr_pkg::*;

  localparam int     SW       = $clog2(TABLE_DEPTH);
  localparam int     STEPS    = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int     CW       = $clog2(STEPS);
  localparam longint SLOT_DIV = 64'd1 + (64'(MOD1) - 64'd1) / TABLE_DEPTH;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [30:0]   first;
  logic [30:0]   gen2;
  logic [30:0]   last;
  logic [SW-1:0] slot;

  logic [46:0]   prod1;
  logic [46:0]   prod2;
  logic [30:0]   g1;
  logic [30:0]   g2;

  logic [30:0]          table_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_vld;
  logic [30:0]          rd_data;
  logic                 rd_vld;

  logic          in_acc;
  logic          reseed;
  logic [31:0]   seed_neg;
  logic [30:0]   mag;
  logic [30:0]   a1;
  logic [30:0]   tbl_rd;
  logic [31:0]   diff;
  logic [31:0]   diff_adj;
  logic [30:0]   new_last;
  logic [SW-1:0] slot_calc;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic          out_free;
  logic          out_load;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_FIN) && out_free;

  assign reseed   = seed[31] || (seed == 32'sd0);
  assign seed_neg = 32'd0 - 32'(seed);

  always_comb begin
    if (seed == 32'sd0) begin
      mag = 31'd1;
    end else if (seed_neg[31]) begin
      mag = 31'h7FFF_FFFF;  // most negative seed saturates
    end else begin
      mag = seed_neg[30:0];
    end
  end

  // first-generator operand of the multiplier
  always_comb begin
    case (state)
      S_IDLE:  a1 = reseed ? mag : seed[30:0];
      S_WUPD:  a1 = g1;
      default: a1 = first;
    endcase
  end

  // Combine shuffled entry and second generator, wrap into 1..MOD1-1.
  assign tbl_rd   = rd_vld ? rd_data : '0;
  assign diff     = {1'b0, tbl_rd} - {1'b0, g2};
  assign diff_adj = diff + {1'b0, MOD1} - 32'd1;
  assign new_last = (diff[31] || diff == 32'd0) ? diff_adj[30:0] : diff[30:0];

  // slot = last / SLOT_DIV, by comparison against every boundary
  always_comb begin
    slot_calc = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if (64'(last) >= 64'(k) * SLOT_DIV) begin
        slot_calc = SW'(k);
      end
    end
  end

  assign wr_en   = (state == S_UPD) || ((state == S_WUPD) && (32'(cnt) < TABLE_DEPTH));
  assign wr_addr = (state == S_UPD) ? slot : cnt[SW-1:0];

  // Modular multiplier pipeline: product stage, then fold stage.
  always_ff @(posedge clk) begin
    prod1 <= 47'(a1) * 47'(MUL1);
    prod2 <= 47'(gen2) * 47'(MUL2);
    g1    <= mod_fold(prod1, FOLD1, MOD1);
    g2    <= mod_fold(prod2, FOLD2, MOD2);
  end

  // Shuffle memory, read continuously at the current slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= g1;
    end
    rd_data <= table_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld[wr_addr] <= 1'b1;
      end
      rd_vld <= entry_vld[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen2      <= GEN2_INIT;
      last      <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      // hold a stalled result, drop an accepted one, raise on a new load
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (reseed) begin
              gen2  <= mag;
              cnt   <= CW'(STEPS - 1);
              state <= S_WFOLD;
            end else begin
              state <= S_FOLD;
            end
          end
        end
        S_WFOLD: begin
          state <= S_WUPD;
        end
        S_WUPD: begin
          first <= g1;
          if (cnt == '0) begin
            last  <= g1;
            state <= S_WSLOT;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_WFOLD;
          end
        end
        S_WSLOT: begin
          slot  <= slot_calc;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          first <= g1;
          gen2  <= g2;
          last  <= new_last;
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            next_seed <= first;
            sample    <= last;
            fraction  <= frac_q32(last);
            slot      <= slot_calc;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
